// File: hw/rtl/sha256_byte_stream_hasher_defines.svh
// Assertion macros shared by the SHA-256 byte stream hasher checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Clocked property, disabled while reset is held
`define SBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SBH_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/sha256_pkg.sv
// Package for the SHA-256 byte stream hasher: widths, sequencer states,
// initial hash values, round constants and the rotate helper. No dependencies.
package sha256_pkg;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CNT_W     = 61;
  localparam int unsigned BLOCK_W   = 512;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef logic [7:0][WORD_W-1:0] hash_t;

  // Word 0 sits in the lowest slot
  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] v, input int unsigned r);
    return (v >> r) | (v << (WORD_W - r));
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [5:0] idx);
    logic [WORD_W-1:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// File: hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: 64-byte shift buffer, one shared round unit
// under a small sequencer. Depends on sha256_pkg.
//
// Flow: a byte that does not complete a block leaves the input ready; the 64th
// byte of a block holds the input through 64 rounds, one per cycle, and the
// hash update. A last item adds padding up to the block end and a compression,
// plus a full padding block and a compression more when the length does not fit
// (and a compression first when the item fills a block), then eight digest
// words, one per handshake.
// Reset (rst_ni low, async): idle, initial hash values, zero byte count;
// the block buffer is not cleared.
module sha256_byte_stream_hasher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [sha256_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic                            s_axis_tuser_i,   // [0] byte_valid
  input  logic                            s_axis_tlast_i,   // is_last
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [sha256_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // [31:0] digest_word,
                                                            // [34:32] word_index
  output logic                            m_axis_tlast_o    // last_word
);

  sha256_pkg::state_e state_q, state_d;

  logic [sha256_pkg::BLOCK_W-1:0] buf_q, buf_d;
  sha256_pkg::hash_t              hash_q, hash_d;
  sha256_pkg::hash_t              work_q, work_d;
  logic [5:0]                     rnd_q, rnd_d;
  logic [sha256_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [5:0]                     pos_q, pos_d;
  logic                           need80_q, need80_d;
  logic                           lenok_q, lenok_d;
  logic                           pad_q, pad_d;
  logic                           done_q, done_d;
  logic [2:0]                     idx_q, idx_d;

  logic s_acc, m_acc, blk_full;

  // Schedule and round signals
  logic [31:0] w_top, w_1, w_9, w_14, s0, s1, w_new;
  logic [31:0] big0, big1, choose, major, t1, t2;
  logic [63:0] bit_len, len_shift;
  logic [7:0]  pad_byte;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc    = m_axis_tvalid_o && m_axis_tready_i;
  assign blk_full = s_axis_tuser_i && (cnt_q[5:0] == sha256_pkg::LAST_POS);

  // Message schedule: sliding 16-word window in the block buffer
  assign w_top = buf_q[511:480];
  assign w_1   = buf_q[479:448];
  assign w_9   = buf_q[223:192];
  assign w_14  = buf_q[63:32];
  assign s0    = sha256_pkg::ror(w_1, 7) ^ sha256_pkg::ror(w_1, 18) ^ (w_1 >> 3);
  assign s1    = sha256_pkg::ror(w_14, 17) ^ sha256_pkg::ror(w_14, 19) ^ (w_14 >> 10);
  assign w_new = w_top + s0 + w_9 + s1;

  // Shared round unit: a..h live in work_q[0]..work_q[7]
  assign big1   = sha256_pkg::ror(work_q[4], 6) ^ sha256_pkg::ror(work_q[4], 11)
                ^ sha256_pkg::ror(work_q[4], 25);
  assign choose = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign t1     = work_q[7] + big1 + choose + sha256_pkg::round_k(rnd_q) + w_top;
  assign big0   = sha256_pkg::ror(work_q[0], 2) ^ sha256_pkg::ror(work_q[0], 13)
                ^ sha256_pkg::ror(work_q[0], 22);
  assign major  = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
                ^ (work_q[1] & work_q[2]);
  assign t2     = big0 + major;

  // Padding byte: 0x80 marker, zero fill, then big-endian bit length
  assign bit_len   = {cnt_q, 3'b000};
  assign len_shift = bit_len << {pos_q[2:0], 3'b000};
  always_comb begin
    if (need80_q) begin
      pad_byte = sha256_pkg::PAD_BYTE;
    end else if (lenok_q && (pos_q >= sha256_pkg::LEN_POS)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (blk_full) begin
            state_d = sha256_pkg::ST_ROUND;
          end else if (s_axis_tlast_i) begin
            state_d = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (pos_q == sha256_pkg::LAST_POS) state_d = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        if (rnd_q == sha256_pkg::LAST_ROUND) state_d = sha256_pkg::ST_FINAL;
      end
      sha256_pkg::ST_FINAL: begin
        if (done_q) begin
          state_d = sha256_pkg::ST_OUT;
        end else if (pad_q) begin
          state_d = sha256_pkg::ST_PAD;
        end else begin
          state_d = sha256_pkg::ST_IDLE;
        end
      end
      sha256_pkg::ST_OUT: begin
        if (m_acc && (idx_q == sha256_pkg::LAST_WORD)) state_d = sha256_pkg::ST_IDLE;
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  // Handshake and result outputs
  always_comb begin
    s_axis_tready_o = (state_q == sha256_pkg::ST_IDLE);
    m_axis_tvalid_o = (state_q == sha256_pkg::ST_OUT);
    m_axis_tdata_o  = {5'b00000, idx_q, hash_q[idx_q]};
    m_axis_tlast_o  = (idx_q == sha256_pkg::LAST_WORD);
  end

  // Datapath next values
  always_comb begin
    buf_d    = buf_q;
    hash_d   = hash_q;
    work_d   = work_q;
    rnd_d    = rnd_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    need80_d = need80_q;
    lenok_d  = lenok_q;
    pad_d    = pad_q;
    done_d   = done_q;
    idx_d    = idx_q;
    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (s_acc) begin
          // Take the byte if marked valid, then arm padding if this item ends the message
          if (s_axis_tuser_i) begin
            buf_d = {buf_q[503:0], s_axis_tdata_i};
            cnt_d = cnt_q + 61'd1;
          end
          pos_d    = cnt_d[5:0];
          pad_d    = s_axis_tlast_i;
          need80_d = 1'b1;
          lenok_d  = 1'b0;
          done_d   = 1'b0;
          work_d   = hash_q;
          rnd_d    = '0;
        end
      end
      sha256_pkg::ST_PAD: begin
        buf_d    = {buf_q[503:0], pad_byte};
        pos_d    = pos_q + 6'd1;
        need80_d = 1'b0;
        if (need80_q) lenok_d = (pos_q < sha256_pkg::LEN_POS);
        // Prepare the next compression; it launches once the block is complete
        work_d = hash_q;
        rnd_d  = '0;
        done_d = !need80_q && lenok_q;
      end
      sha256_pkg::ST_ROUND: begin
        buf_d     = {buf_q[479:0], w_new};
        work_d[7] = work_q[6];
        work_d[6] = work_q[5];
        work_d[5] = work_q[4];
        work_d[4] = work_q[3] + t1;
        work_d[3] = work_q[2];
        work_d[2] = work_q[1];
        work_d[1] = work_q[0];
        work_d[0] = t1 + t2;
        rnd_d     = rnd_q + 6'd1;
      end
      sha256_pkg::ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + work_q[i];
        end
        // Length did not fit: the extra block carries it
        if (!done_q && pad_q) lenok_d = 1'b1;
      end
      sha256_pkg::ST_OUT: begin
        if (m_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == sha256_pkg::LAST_WORD) begin
            hash_d = sha256_pkg::H_INIT;
            cnt_d  = '0;
            pad_d  = 1'b0;
            done_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha256_pkg::ST_IDLE;
      hash_q   <= sha256_pkg::H_INIT;
      cnt_q    <= '0;
      rnd_q    <= '0;
      pos_q    <= '0;
      need80_q <= 1'b0;
      lenok_q  <= 1'b0;
      pad_q    <= 1'b0;
      done_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      hash_q   <= hash_d;
      cnt_q    <= cnt_d;
      rnd_q    <= rnd_d;
      pos_q    <= pos_d;
      need80_q <= need80_d;
      lenok_q  <= lenok_d;
      pad_q    <= pad_d;
      done_q   <= done_d;
      idx_q    <= idx_d;
    end
  end

  // Payload: block buffer and working variables
  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    work_q <= work_d;
  end

endmodule

// File: hw/rtl/sha256_checker.sv
// Port-level checker for the SHA-256 byte stream hasher, bound to the top.
// Depends on sha256_pkg and sha256_byte_stream_hasher_defines.svh.
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [sha256_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o
);

  // Digest output and byte intake never overlap
  `SBH_ASSERT(a_out_blocks_in, m_axis_tvalid_o |-> !s_axis_tready_o, "input ready during digest output")

  // An ending item occupies the block for padding or compression
  `SBH_ASSERT_NEXT(a_last_busy, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o, "ready right after last item")

  // Words before the last keep the digest going
  `SBH_ASSERT_NEXT(a_more_words, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o, "digest ended early")

  // The last word closes the digest
  `SBH_ASSERT_NEXT(a_end_words, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, !m_axis_tvalid_o, "extra digest word")

  // A stalled result item holds
  `SBH_ASSERT_NEXT(a_hold_out, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled item changed")

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (.*);
